@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the following clock
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pbps_pkg.sv @@
// ----------------------------------------------------------------------------
// pbps_pkg: shared types and constants
// Widths, outcome codes and the front/back queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pbps_pkg;
  localparam int SLOTS_DEF   = 8;
  localparam int SOURCES_DEF = 16;
  localparam int SRC_W  = 4;
  localparam int TIME_W = 32;
  localparam int TAG_W  = 16;
  localparam int OUTC_W = 3;
  localparam int SLOT_W = 3;

  localparam logic [OUTC_W-1:0] OC_STORED  = 3'd0;
  localparam logic [OUTC_W-1:0] OC_DISPL   = 3'd1;
  localparam logic [OUTC_W-1:0] OC_REJECT  = 3'd2;
  localparam logic [OUTC_W-1:0] OC_EMIT    = 3'd3;
  localparam logic [OUTC_W-1:0] OC_NOTHING = 3'd4;

  typedef struct packed {
    logic              emit;
    logic [SRC_W-1:0]  source;
    logic [TIME_W-1:0] created;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic [SRC_W-1:0]  source;
    logic [TIME_W-1:0] created;
    logic              any_stored;
  } res_t;
endpackage

@@ design/pbps_if.sv @@
// ----------------------------------------------------------------------------
// pbps_in_if / pbps_out_if: valid/ready channels
// Input request channel and result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface pbps_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  source;
  logic [31:0] created_ts;
  logic [15:0] tag;
  modport source_mp (output valid, mode, source, created_ts, tag, input ready);
  modport sink_mp   (input valid, mode, source, created_ts, tag, output ready);
endinterface

interface pbps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [2:0]  slot;
  logic [15:0] out_tag;
  logic [3:0]  out_source;
  logic [31:0] out_created;
  logic        any_stored;
  modport source_mp (output valid, outcome, slot, out_tag, out_source, out_created,
                     any_stored, input ready);
  modport sink_mp   (input valid, outcome, slot, out_tag, out_source, out_created,
                     any_stored, output ready);
endinterface

@@ design/pbps_front.sv @@
// ----------------------------------------------------------------------------
// pbps_front: command intake
// Takes input transactions and pushes them into a two-entry command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pbps_front (
  input  logic          clk,
  input  logic          rst_n,
  pbps_in_if.sink_mp    in_ch,
  output pbps_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import pbps_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{emit: in_ch.mode, source: in_ch.source,
                     created: in_ch.created_ts, tag: in_ch.tag};
    end
  end
endmodule

@@ design/pbps_back.sv @@
// ----------------------------------------------------------------------------
// pbps_back: slot engine
// Scans slots one per cycle to place, displace or emit a request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pbps_back #(
  parameter int SLOTS = pbps_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pbps_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output pbps_pkg::res_t res,
  output logic           res_valid,
  input  logic           res_ready
);
  import pbps_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FREE = 6'b000010,
    S_DISP = 6'b000100,
    S_MIN  = 6'b001000,
    S_PICK = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t            st_r, st_nxt;
  cmd_t              cmd_r;
  logic [SLOTS-1:0]  valid_r, pkt_r;
  logic [SRC_W-1:0]  src_m [SLOTS];
  logic [TIME_W-1:0] time_m [SLOTS];
  logic [TAG_W-1:0]  tag_m [SLOTS];
  logic [IW-1:0]     ptr_r, idx_r, pick_r;
  logic [CW-1:0]     cnt_r;
  logic              have_r, formed_r;
  logic [SRC_W-1:0]  best_r;
  logic [TIME_W-1:0] bt_r;
  res_t              res_r;
  logic              res_valid_r;
  logic [IW-1:0]     idx_inc;
  logic              last;
  logic              inpk;

  assign res       = res_r;
  assign res_valid = res_valid_r;
  assign idx_inc   = (idx_r == IW'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign last      = (cnt_r == CW'(SLOTS - 1));
  assign cmd_pop   = (st_r == S_IDLE) && cmd_valid && !res_valid_r;
  assign inpk      = formed_r ? (valid_r[idx_r] && src_m[idx_r] == best_r)
                              : (pkt_r[idx_r] && valid_r[idx_r]);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (cmd_pop) st_nxt = cmd.emit ? (|valid_r ? (|(pkt_r & valid_r) ? S_PICK
                                   : S_MIN) : S_OUT) : S_FREE;
      S_FREE: if (!valid_r[idx_r]) st_nxt = S_OUT; else if (last) st_nxt = S_DISP;
      S_DISP: if (cmd_r.source < src_m[idx_r] || last) st_nxt = S_OUT;
      S_MIN:  if (last) st_nxt = S_PICK;
      S_PICK: if (last) st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      valid_r     <= '0;
      pkt_r       <= '0;
      ptr_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_pop) begin
            cmd_r    <= cmd;
            idx_r    <= cmd.emit ? '0 : ptr_r;
            cnt_r    <= '0;
            have_r   <= 1'b0;
            formed_r <= 1'b0;
            best_r   <= '1;
            res_r    <= '{outcome: (cmd.emit && !(|valid_r)) ? OC_NOTHING : OC_STORED,
                          default: '0};
          end
        end
        S_FREE: begin
          if (!valid_r[idx_r]) begin
            valid_r[idx_r] <= 1'b1;
            pkt_r[idx_r]   <= 1'b0;
            src_m[idx_r]   <= cmd_r.source;
            time_m[idx_r]  <= cmd_r.created;
            tag_m[idx_r]   <= cmd_r.tag;
            ptr_r          <= idx_inc;
            res_r.outcome  <= OC_STORED;
            res_r.slot     <= SLOT_W'(idx_r);
          end else begin
            idx_r <= idx_inc;
            cnt_r <= last ? '0 : cnt_r + 1'b1;
          end
        end
        S_DISP: begin
          if (cmd_r.source < src_m[idx_r]) begin
            res_r.outcome <= OC_DISPL;
            res_r.slot    <= SLOT_W'(idx_r);
            res_r.tag     <= tag_m[idx_r];
            res_r.source  <= src_m[idx_r];
            res_r.created <= time_m[idx_r];
            pkt_r[idx_r]  <= 1'b0;
            src_m[idx_r]  <= cmd_r.source;
            time_m[idx_r] <= cmd_r.created;
            tag_m[idx_r]  <= cmd_r.tag;
            ptr_r         <= idx_inc;
          end else if (last) begin
            res_r.outcome <= OC_REJECT;
            res_r.tag     <= cmd_r.tag;
            res_r.source  <= cmd_r.source;
            res_r.created <= cmd_r.created;
          end
          idx_r <= idx_inc;
          cnt_r <= cnt_r + 1'b1;
        end
        S_MIN: begin
          if (valid_r[idx_r] && src_m[idx_r] < best_r) best_r <= src_m[idx_r];
          idx_r    <= idx_inc;
          cnt_r    <= last ? '0 : cnt_r + 1'b1;
          formed_r <= last;
        end
        S_PICK: begin
          if (inpk && (!have_r || time_m[idx_r] < bt_r)) begin
            have_r <= 1'b1;
            pick_r <= idx_r;
            bt_r   <= time_m[idx_r];
          end
          if (formed_r) pkt_r[idx_r] <= inpk;
          idx_r <= idx_inc;
          cnt_r <= cnt_r + 1'b1;
        end
        S_OUT: begin
          res_valid_r <= 1'b1;
          if (res_r.outcome == OC_EMIT || (have_r && cmd_r.emit)) begin
            res_r.outcome    <= OC_EMIT;
            res_r.slot       <= SLOT_W'(pick_r);
            res_r.tag        <= tag_m[pick_r];
            res_r.source     <= src_m[pick_r];
            res_r.created    <= time_m[pick_r];
            valid_r[pick_r]  <= 1'b0;
            pkt_r[pick_r]    <= 1'b0;
            res_r.any_stored <= |(valid_r & ~(SLOTS'(1) << pick_r));
          end else begin
            res_r.any_stored <= |valid_r;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ design/priority_buffer_with_packet_service.sv @@
// Sequence: an arrival runs the free-slot scan, then the displacement scan when no slot
// is free; an emit runs the pick scan, after a minimum scan when the packet is re-formed;
// an emit on an empty buffer goes straight to the result.
// Throughput: one transaction at a time in the slot engine, one slot looked at per cycle;
// the engine waits until its result is taken; a two-entry queue keeps the input side going.
// Reset: synchronous, active low; all slots empty, packet empty, pointer at slot 0.
// ----------------------------------------------------------------------------
// priority_buffer_with_packet_service: top level
// Slot buffer with preemption by source and packet-wise service.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module priority_buffer_with_packet_service #(
  parameter int SLOTS   = pbps_pkg::SLOTS_DEF,
  parameter int SOURCES = pbps_pkg::SOURCES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pbps_in_if.sink_mp    in_ch,
  pbps_out_if.source_mp out_ch
);
  import pbps_pkg::*;

  // Source numbers are compared as plain 4-bit values whatever SOURCES is.

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_pop, res_valid;

  // Front: intake queue, decoupled from the slot engine.
  pbps_front u_front (
    .clk, .rst_n, .in_ch, .cmd, .cmd_valid, .cmd_pop
  );

  // Back: slot scans and the result register.
  pbps_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .cmd, .cmd_valid, .cmd_pop,
    .res, .res_valid, .res_ready(out_ch.ready)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.outcome     = res.outcome;
  assign out_ch.slot        = res.slot;
  assign out_ch.out_tag     = res.tag;
  assign out_ch.out_source  = res.source;
  assign out_ch.out_created = res.created;
  assign out_ch.any_stored  = res.any_stored;
endmodule

@@ design/pbps_checker.sv @@
// ----------------------------------------------------------------------------
// pbps_checker: port-level checks
// Result channel sanity and handshake rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] outcome,
  input logic [2:0] slot,
  input logic       any_stored
);
  import pbps_pkg::*;

  logic is_store, is_none;

  assign is_store = out_valid && (outcome == OC_STORED || outcome == OC_DISPL);
  assign is_none  = out_valid && outcome == OC_NOTHING;

  `CHK_IMPLY(a_code, clk, rst_n, out_valid, outcome <= OC_NOTHING, "bad outcome")
  `CHK_IMPLY(a_store, clk, rst_n, is_store, any_stored, "stored but empty")
  `CHK_IMPLY(a_none, clk, rst_n, is_none, !any_stored && slot == 3'd0, "nothing case")
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(outcome), "stall dropped")
endmodule

bind priority_buffer_with_packet_service pbps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .outcome(out_ch.outcome), .slot(out_ch.slot), .any_stored(out_ch.any_stored)
);
